// File: src/assert_macros.svh
// Assertion macros shared by the hasher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check a condition in the cycle after an antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: src/shabs_pkg.sv
// Package with SHA-256 constants, types and round functions.
package shabs_pkg;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenPos = 56;
  localparam logic [7:0] PadByte = 8'h80;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StLoad  = 6'b000010,
    StRound = 6'b000100,
    StAdd   = 6'b001000,
    StPad   = 6'b010000,
    StOut   = 6'b100000
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic       write_byte;
    logic [7:0] wbyte;
    logic       count_inc;
    logic       round_init;
    logic       round_step;
    logic       chain_add;
    logic       clear_all;
    logic       out_shift;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [5:0]  fill;
    logic [5:0]  round;
    logic [63:0] bits;
  } stat_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[i];
  endfunction

  function automatic logic [255:0] init_h();
    return {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned s);
    return (x >> s) | (x << (32 - s));
  endfunction
endpackage

// File: src/shabs_ctrl.sv
// Controller state machine for the byte-stream hasher.
module shabs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              cmd_i,
  input  logic [7:0]        data_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        word_index_o,
  output logic              last_word_o,
  input  shabs_pkg::stat_t  stat_i,
  output shabs_pkg::cmd_t   cmd_o
);
  shabs_pkg::state_e state_q, state_d;
  logic       fin_q, fin_d;
  logic       len_ok_q, len_ok_d;
  logic       done_q, done_d;
  logic [2:0] widx_q, widx_d;
  logic       acc;

  assign in_stall_o   = (state_q != shabs_pkg::StIdle);
  assign acc          = in_valid_i && !in_stall_o;
  assign out_valid_o  = (state_q == shabs_pkg::StOut);
  assign word_index_o = widx_q;
  assign last_word_o  = (widx_q == 3'd7);

  // Sequence byte loads, padding, rounds and digest output.
  always_comb begin
    state_d  = state_q;
    fin_d    = fin_q;
    len_ok_d = len_ok_q;
    done_d   = done_q;
    widx_d   = widx_q;
    cmd_o    = '0;
    case (state_q)
      shabs_pkg::StIdle: begin
        if (acc) begin
          cmd_o.write_byte = 1'b1;
          if (cmd_i) begin
            cmd_o.wbyte = shabs_pkg::PadByte;
            fin_d = 1'b1;
            // Length fits in this block only when the pad byte lands before it.
            len_ok_d = (stat_i.fill < 6'(shabs_pkg::LenPos));
            done_d = 1'b0;
          end else begin
            cmd_o.wbyte = data_byte_i;
            cmd_o.count_inc = 1'b1;
            fin_d = 1'b0;
          end
          state_d = shabs_pkg::StLoad;
        end
      end
      shabs_pkg::StLoad: begin
        if (stat_i.fill == 6'd0) begin
          cmd_o.round_init = 1'b1;
          state_d = shabs_pkg::StRound;
        end else if (fin_q) begin
          state_d = shabs_pkg::StPad;
        end else begin
          state_d = shabs_pkg::StIdle;
        end
      end
      shabs_pkg::StRound: begin
        cmd_o.round_step = 1'b1;
        if (stat_i.round == 6'd63) state_d = shabs_pkg::StAdd;
      end
      shabs_pkg::StAdd: begin
        cmd_o.chain_add = 1'b1;
        if (fin_q && done_q) begin
          widx_d  = 3'd0;
          state_d = shabs_pkg::StOut;
        end else if (fin_q) begin
          len_ok_d = 1'b1;
          state_d  = shabs_pkg::StPad;
        end else state_d = shabs_pkg::StIdle;
      end
      shabs_pkg::StPad: begin
        // Write zero up to the length field, then the length bytes.
        cmd_o.write_byte = 1'b1;
        if (!len_ok_q || stat_i.fill < 6'(shabs_pkg::LenPos)) cmd_o.wbyte = 8'h00;
        else cmd_o.wbyte = stat_i.bits[{3'(6'd63 - stat_i.fill), 3'b000} +: 8];
        state_d = shabs_pkg::StLoad;
        if (len_ok_q && stat_i.fill == 6'd63) done_d = 1'b1;
      end
      shabs_pkg::StOut: begin
        if (!out_stall_i) begin
          cmd_o.out_shift = 1'b1;
          widx_d = widx_q + 3'd1;
          if (widx_q == 3'd7) begin
            cmd_o.clear_all = 1'b1;
            fin_d    = 1'b0;
            len_ok_d = 1'b0;
            done_d   = 1'b0;
            state_d  = shabs_pkg::StIdle;
          end
        end
      end
      default: state_d = shabs_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= shabs_pkg::StIdle;
      fin_q    <= 1'b0;
      len_ok_q <= 1'b0;
      done_q   <= 1'b0;
      widx_q   <= 3'd0;
    end else begin
      state_q  <= state_d;
      fin_q    <= fin_d;
      len_ok_q <= len_ok_d;
      done_q   <= done_d;
      widx_q   <= widx_d;
    end
  end
endmodule

// File: src/shabs_datapath.sv
// Datapath: block store, schedule, round unit, chaining words and counters.
module shabs_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  shabs_pkg::cmd_t   cmd_i,
  output shabs_pkg::stat_t  stat_o,
  output logic [31:0]       digest_word_o
);
  logic [31:0]  w_q [16];
  logic [31:0]  v_q [8];
  logic [255:0] h_q;
  logic [60:0]  cnt_q;
  logic [5:0]   fill_q, rnd_q;
  logic [31:0]  wnew, s0, s1, t1, t2, e, a;

  // Message schedule as a 16-word shift line.
  assign s0   = shabs_pkg::ror(w_q[1], 7) ^ shabs_pkg::ror(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1   = shabs_pkg::ror(w_q[14], 17) ^ shabs_pkg::ror(w_q[14], 19) ^ (w_q[14] >> 10);
  assign wnew = w_q[0] + s0 + w_q[9] + s1;
  assign e    = v_q[4];
  assign a    = v_q[0];
  assign t1   = v_q[7] + (shabs_pkg::ror(e, 6) ^ shabs_pkg::ror(e, 11) ^ shabs_pkg::ror(e, 25))
              + ((e & v_q[5]) ^ (~e & v_q[6])) + shabs_pkg::round_k(rnd_q) + w_q[0];
  assign t2   = (shabs_pkg::ror(a, 2) ^ shabs_pkg::ror(a, 13) ^ shabs_pkg::ror(a, 22))
              + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));

  assign stat_o.fill  = fill_q;
  assign stat_o.round = rnd_q;
  assign stat_o.bits  = {cnt_q, 3'b000};
  assign digest_word_o = h_q[255:224];

  // Load bytes into the schedule line; bytes shift in from the low end.
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_byte) begin
      w_q[fill_q[5:2]] <= {w_q[fill_q[5:2]][23:0], cmd_i.wbyte};
    end else if (cmd_i.round_step) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
      w_q[15] <= wnew;
    end
    if (cmd_i.round_init) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[255 - 32 * i -: 32];
    end else if (cmd_i.round_step) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  // Hold chaining words and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q    <= shabs_pkg::init_h();
      cnt_q  <= '0;
      fill_q <= '0;
      rnd_q  <= '0;
    end else begin
      if (cmd_i.clear_all) begin
        h_q    <= shabs_pkg::init_h();
        cnt_q  <= '0;
        fill_q <= '0;
      end else begin
        if (cmd_i.out_shift) h_q <= {h_q[223:0], h_q[255:224]};
        if (cmd_i.chain_add) begin
          for (int i = 0; i < 8; i++)
            h_q[255 - 32 * i -: 32] <= h_q[255 - 32 * i -: 32] + v_q[i];
        end
        if (cmd_i.write_byte) fill_q <= fill_q + 6'd1;
        if (cmd_i.count_inc) cnt_q <= cnt_q + 61'd1;
      end
      if (cmd_i.round_init) rnd_q <= '0;
      else if (cmd_i.round_step) rnd_q <= rnd_q + 6'd1;
    end
  end
endmodule

// File: src/sha256_byte_stream_hasher_unit.sv
// Top level of the SHA-256 byte-stream hasher.
// Absorb item: the byte is written and checked in the load state; a full block then runs
// 64 rounds and the chaining add. Finish item: pad and length bytes go the same way, then
// eight digest words at one per cycle when not stalled.
// Reset (asynchronous, active low) restores the initial hash values and clears counts.
`include "assert_macros.svh"
module sha256_byte_stream_hasher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  shabs_pkg::cmd_t  cmd;
  shabs_pkg::stat_t stat;

  shabs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i, .data_byte_i,
    .out_valid_o, .out_stall_i, .word_index_o, .last_word_o,
    .stat_i(stat), .cmd_o(cmd)
  );

  shabs_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .digest_word_o
  );

  `ASSERT_IMPL(no_in_during_out, clk_i, rst_ni, out_valid_o, in_stall_o)
  `ASSERT_NEXT(idx_adv, clk_i, rst_ni, out_valid_o && !out_stall_i && !last_word_o,
               out_valid_o)
endmodule

// File: bench/sha256_byte_stream_hasher_unit_test.sv
// Self-checking testbench for the SHA-256 byte-stream hasher.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher_unit_test;
  localparam logic CmdAbsorb = 1'b0;
  localparam logic CmdFinish = 1'b1;
  localparam int unsigned CycleLimit = 2000000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        cmd_i;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  sha256_byte_stream_hasher_unit dut (.*);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_item_t;

  typedef struct {
    logic        cmd;
    logic [7:0]  data;
    logic        known;
    logic [31:0] word0;
  } stim_row_t;

  // Predictor state
  logic [31:0] hash_state [8];
  logic [60:0] msg_bytes;
  logic [7:0]  block_buf [64];
  logic [5:0]  buf_fill;

  digest_item_t digest_q [$];
  logic [31:0]  known_word0_q [$];
  logic         known_flag_q [$];
  int unsigned  mismatches = 0;
  int unsigned  cycles = 0;
  bit           stim_done = 0;

  localparam logic [31:0] InitWords [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
    32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(logic [31:0] x, int s);
    return (x >> s) | (x << (32 - s));
  endfunction

  task automatic hash_clear();
    for (int i = 0; i < 8; i++) hash_state[i] = InitWords[i];
    msg_bytes = '0;
    buf_fill = '0;
  endtask

  task automatic compress_buf();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic buf_push(logic [7:0] b);
    block_buf[buf_fill] = b;
    buf_fill = buf_fill + 6'd1;
    if (buf_fill == 6'd0) compress_buf();
  endtask

  // Advance the predictor by one accepted item and queue any digest words
  task automatic predict_digest(logic cmd, logic [7:0] data);
    logic [63:0] bits;
    if (cmd == CmdAbsorb) begin
      buf_push(data);
      msg_bytes = msg_bytes + 61'd1;
    end else begin
      bits = {msg_bytes, 3'b000};
      buf_push(8'h80);
      while (buf_fill != 6'd56) buf_push(8'h00);
      for (int i = 0; i < 8; i++) buf_push(bits[63 - 8*i -: 8]);
      for (int i = 0; i < 8; i++)
        digest_q.push_back('{hash_state[i], 3'(i), i == 7});
      hash_clear();
    end
  endtask

  // Clock
  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Check accepted digest words against the oldest expectation
  always @(posedge clk_i) begin
    digest_item_t want;
    logic bad;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest word %h", digest_word_o);
      end else begin
        want = digest_q.pop_front();
        bad = (want.word !== digest_word_o) || (want.index !== word_index_o)
           || (want.last !== last_word_o);
        // Typed-in first word of directed rows
        if (want.index == 0 && known_flag_q.size() > 0) begin
          if (known_flag_q[0] && known_word0_q[0] !== digest_word_o) bad = 1;
          void'(known_flag_q.pop_front());
          void'(known_word0_q.pop_front());
        end
        if (bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h/%0d/%b got %h/%0d/%b", want.word, want.index,
                     want.last, digest_word_o, word_index_o, last_word_o);
        end
      end
    end
  end

  // Receiver stall: draw a wait for every word
  initial begin
    int unsigned gap;
    out_stall_i <= 1'b1;
    @(posedge rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic send_item(logic cmd, logic [7:0] data, bit burst);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    data_byte_i <= data;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_digest(cmd, data);
  endtask

  // Stimulus
  initial begin
    stim_row_t rows [$];
    int unsigned len;
    bit burst;
    in_valid_i  <= 1'b0;
    cmd_i       <= CmdAbsorb;
    data_byte_i <= 8'h00;
    rst_ni      <= 1'b0;
    hash_clear();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, "abc", extremes of the byte, finish ignores data
    rows.push_back('{CmdFinish, 8'hff, 1'b1, 32'he3b0c442});
    rows.push_back('{CmdAbsorb, 8'h61, 1'b0, 32'h0});
    rows.push_back('{CmdAbsorb, 8'h62, 1'b0, 32'h0});
    rows.push_back('{CmdAbsorb, 8'h63, 1'b0, 32'h0});
    rows.push_back('{CmdFinish, 8'h00, 1'b1, 32'hba7816bf});
    rows.push_back('{CmdAbsorb, 8'h00, 1'b0, 32'h0});
    rows.push_back('{CmdFinish, 8'h55, 1'b0, 32'h0});
    rows.push_back('{CmdAbsorb, 8'hff, 1'b0, 32'h0});
    rows.push_back('{CmdAbsorb, 8'haa, 1'b0, 32'h0});
    rows.push_back('{CmdFinish, 8'h00, 1'b0, 32'h0});
    rows.push_back('{CmdFinish, 8'h00, 1'b1, 32'he3b0c442});
    foreach (rows[i]) begin
      if (rows[i].cmd == CmdFinish) begin
        known_flag_q.push_back(rows[i].known);
        known_word0_q.push_back(rows[i].word0);
      end
      send_item(rows[i].cmd, rows[i].data, 1'b0);
    end

    // Random messages: mostly short, a few crossing block and pad boundaries
    for (int n = 0; n < 300; ) begin
      case ($urandom_range(0, 5))
        0: len = $urandom_range(55, 57);
        1: len = $urandom_range(63, 65);
        default: len = $urandom_range(0, 20);
      endcase
      if (len > 299 - n) len = 299 - n;
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) send_item(CmdAbsorb, 8'($urandom), burst);
      send_item(CmdFinish, 8'($urandom), burst);
      n += len + 1;
    end
    in_valid_i <= 1'b0;
    stim_done = 1;
  end

  // End of run
  initial begin
    wait (stim_done);
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
